@@ rtl/oversample_with_last_good_fallback_defines.svh @@
// Assertion helpers shared by the RTL of the oversampling block.
// Each helper expects signals named clk and rst in the module that uses it.
`ifndef OVERSAMPLE_WITH_LAST_GOOD_FALLBACK_DEFINES_SVH
`define OVERSAMPLE_WITH_LAST_GOOD_FALLBACK_DEFINES_SVH

// The condition holds at every clock edge outside reset.
`define OVSF_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define OVSF_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define OVSF_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/ovsf_pkg.sv @@
package ovsf_pkg;

  localparam int DEF_OVERSAMPLE_N  = 16;
  localparam int DEF_CHANNEL_SLOTS = 16;
  localparam int DEF_SAMPLE_BITS   = 12;

  localparam int FIELD_W   = 12;
  localparam int CHAN_W    = 4;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 4;

  localparam int OPQ_DEPTH  = 4;
  localparam int RESQ_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] REG_PROBE_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_A_CHANNEL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B_CHANNEL  = 2'd2;

  localparam logic [MODE_W-1:0] MODE_A = 2'd0;
  localparam logic [MODE_W-1:0] MODE_B = 2'd1;

  localparam logic [MODE_W-1:0] RST_PROBE_MODE = 2'd2;
  localparam logic [CHAN_W-1:0] RST_A_CHANNEL  = 4'd0;
  localparam logic [CHAN_W-1:0] RST_B_CHANNEL  = 4'd1;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_CONV  = 1'b1;

  typedef enum logic {
    OP_START  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_kind_t;

  typedef struct packed {
    logic               command;
    logic [FIELD_W-1:0] sample;
    logic               sample_ok;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] probe_a_avg;
    logic [FIELD_W-1:0] probe_b_avg;
    logic [FIELD_W-1:0] combined;
    logic               stalled;
  } out_item_t;

  typedef struct packed {
    logic [MODE_W-1:0] probe_mode;
    logic [CHAN_W-1:0] probe_a_channel;
    logic [CHAN_W-1:0] probe_b_channel;
  } cfg_t;

  typedef struct packed {
    op_kind_t           kind;
    logic               probe_b;
    logic               last;
    logic [CHAN_W-1:0]  slot;
    logic [FIELD_W-1:0] value;
    logic               ok;
  } op_t;

endpackage

@@ rtl/oversample_with_last_good_fallback.sv @@
`include "oversample_with_last_good_fallback_defines.svh"

// Two-probe oversampling front end with last-good substitution.
// Input queue side: drive item and push; the beat is taken when full is low.
// A start command opens a run; then the block expects one settle conversion
// and OVERSAMPLE_N samples for probe A, then the same for probe B. Failed
// samples take the last good value of their channel slot.
// Result queue side: while empty is low the oldest result is on result, and
// pop takes it. One result follows the last probe B sample of each run.
// Configuration beats use cfg_valid, cfg_ready, cfg_index and cfg_data and
// should only be sent while the block is idle.
// Throughput is one beat per cycle while full is low; the back end updates
// the store and accumulates each sample op that it pops. A result passes from
// the back end through finish stages s1 and s2 into the result queue.
// When the receiver stops popping, up to four results wait; the back end
// then holds the final sample of the next run at the head of the op queue,
// and full rises once three more start or sample beats sit behind it.
// Reset clears all slots of the last-good store to zero, closes any run,
// empties both queues and loads the registers with their defaults.
module oversample_with_last_good_fallback #(
  parameter int OVERSAMPLE_N  = ovsf_pkg::DEF_OVERSAMPLE_N,
  parameter int CHANNEL_SLOTS = ovsf_pkg::DEF_CHANNEL_SLOTS,
  parameter int SAMPLE_BITS   = ovsf_pkg::DEF_SAMPLE_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  ovsf_pkg::in_item_t               item,
  output logic                            full,
  input  logic                            pop,
  output ovsf_pkg::out_item_t              result,
  output logic                            empty,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ovsf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ovsf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ovsf_pkg::*;

  localparam int SUM_W  = SAMPLE_BITS + $clog2(OVERSAMPLE_N + 1);
  localparam int OP_W   = $bits(op_t);
  localparam int RES_W  = $bits(out_item_t);

  cfg_t             cfg;
  op_t              op_in;
  op_t              op_out;
  logic [OP_W-1:0]  op_rdata;
  logic             op_push;
  logic             op_full;
  logic             op_empty;
  logic             op_pop;
  logic             issue;
  logic [SUM_W-1:0] sum_a;
  logic [SUM_W-1:0] sum_b;
  logic             stalled;
  logic             res_push;
  out_item_t        res;
  logic [RES_W-1:0] res_rdata;
  logic             res_pop;
  logic             res_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.probe_mode      <= RST_PROBE_MODE;
      cfg.probe_a_channel <= RST_A_CHANNEL;
      cfg.probe_b_channel <= RST_B_CHANNEL;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PROBE_MODE: cfg.probe_mode      <= cfg_data[MODE_W-1:0];
        REG_A_CHANNEL:  cfg.probe_a_channel <= cfg_data;
        REG_B_CHANNEL:  cfg.probe_b_channel <= cfg_data;
        default: ;
      endcase
    end
  end

  ovsf_front #(
    .OVERSAMPLE_N  (OVERSAMPLE_N),
    .CHANNEL_SLOTS (CHANNEL_SLOTS),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .push    (push),
    .item    (item),
    .full    (full),
    .op_push (op_push),
    .op      (op_in),
    .op_full (op_full)
  );

  ovsf_fifo #(
    .WIDTH (OP_W),
    .DEPTH (OPQ_DEPTH)
  ) u_opq (
    .clk   (clk),
    .rst   (rst),
    .push  (op_push),
    .wdata (op_in),
    .full  (op_full),
    .pop   (op_pop),
    .rdata (op_rdata),
    .empty (op_empty)
  );

  assign op_out = op_t'(op_rdata);

  ovsf_back #(
    .OVERSAMPLE_N  (OVERSAMPLE_N),
    .CHANNEL_SLOTS (CHANNEL_SLOTS),
    .SAMPLE_BITS   (SAMPLE_BITS),
    .SUM_W         (SUM_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .op       (op_out),
    .op_valid (!op_empty),
    .op_pop   (op_pop),
    .res_pop  (res_pop),
    .issue    (issue),
    .sum_a    (sum_a),
    .sum_b    (sum_b),
    .stalled  (stalled)
  );

  ovsf_finish #(
    .OVERSAMPLE_N (OVERSAMPLE_N),
    .SUM_W        (SUM_W)
  ) u_finish (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .issue    (issue),
    .sum_a    (sum_a),
    .sum_b    (sum_b),
    .stalled  (stalled),
    .res_push (res_push),
    .res      (res)
  );

  assign res_pop = pop && !empty;

  ovsf_fifo #(
    .WIDTH (RES_W),
    .DEPTH (RESQ_DEPTH)
  ) u_resq (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

  assign result = out_item_t'(res_rdata);

  `OVSF_ALWAYS(a_cfg_ready, cfg_ready, "configuration channel not ready")
  `OVSF_IMPLIES(a_op_room, op_push, !op_full, "op pushed into a full queue")
  `OVSF_IMPLIES(a_res_room, res_push, !res_full, "result pushed into a full queue")

endmodule

@@ rtl/ovsf_fifo.sv @@
module ovsf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/ovsf_front.sv @@
module ovsf_front #(
  parameter int OVERSAMPLE_N  = 16,
  parameter int CHANNEL_SLOTS = 16,
  parameter int SAMPLE_BITS   = 12
) (
  input  logic              clk,
  input  logic              rst,
  input  ovsf_pkg::cfg_t     cfg,
  input  logic              push,
  input  ovsf_pkg::in_item_t item,
  output logic              full,
  output logic              op_push,
  output ovsf_pkg::op_t      op,
  input  logic              op_full
);
  import ovsf_pkg::*;

  localparam int PHASE_W = $clog2(2 * OVERSAMPLE_N + 2);
  localparam int SLOT_W  = $clog2(CHANNEL_SLOTS);
  localparam logic [PHASE_W-1:0] A_LAST   = PHASE_W'(OVERSAMPLE_N);
  localparam logic [PHASE_W-1:0] B_SETTLE = PHASE_W'(OVERSAMPLE_N + 1);
  localparam logic [PHASE_W-1:0] B_LAST   = PHASE_W'(2 * OVERSAMPLE_N + 1);

  logic               run_open;
  logic [PHASE_W-1:0] phase;
  logic               accept;
  logic               is_start;
  logic               is_a;
  logic               is_b;
  logic [CHAN_W-1:0]  chan;
  logic [SLOT_W-1:0]  slot_lut [16];

  for (genvar i = 0; i < 16; i++) begin : g_slot
    assign slot_lut[i] = SLOT_W'(i % CHANNEL_SLOTS);
  end

  assign full     = op_full;
  assign accept   = push && !op_full;
  assign is_start = (item.command == CMD_START);
  assign is_a     = run_open && (phase != '0) && (phase <= A_LAST);
  assign is_b     = run_open && (phase > B_SETTLE);
  assign chan     = is_b ? cfg.probe_b_channel : cfg.probe_a_channel;
  assign op_push  = accept && (is_start || is_a || is_b);

  always_comb begin
    op.kind    = is_start ? OP_START : OP_SAMPLE;
    op.probe_b = is_b;
    op.last    = (phase == A_LAST) || (phase == B_LAST);
    op.slot    = CHAN_W'(slot_lut[chan]);
    op.value   = FIELD_W'(SAMPLE_BITS'(item.sample));
    op.ok      = item.sample_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_open <= 1'b0;
      phase    <= '0;
    end else if (accept) begin
      if (is_start) begin
        run_open <= 1'b1;
        phase    <= '0;
      end else if (run_open) begin
        if (phase == B_LAST) begin
          run_open <= 1'b0;
          phase    <= '0;
        end else begin
          phase <= phase + 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/ovsf_back.sv @@
`include "oversample_with_last_good_fallback_defines.svh"

module ovsf_back #(
  parameter int OVERSAMPLE_N  = 16,
  parameter int CHANNEL_SLOTS = 16,
  parameter int SAMPLE_BITS   = 12,
  parameter int SUM_W         = 17
) (
  input  logic             clk,
  input  logic             rst,
  input  ovsf_pkg::op_t     op,
  input  logic             op_valid,
  output logic             op_pop,
  input  logic             res_pop,
  output logic             issue,
  output logic [SUM_W-1:0] sum_a,
  output logic [SUM_W-1:0] sum_b,
  output logic             stalled
);
  import ovsf_pkg::*;

  localparam int SLOT_W = $clog2(CHANNEL_SLOTS);
  localparam int FAIL_W = $clog2(2 * OVERSAMPLE_N + 1);
  localparam int CRED_W = $clog2(RESQ_DEPTH + 1);
  localparam logic [CRED_W-1:0] MAX_CRED = CRED_W'(RESQ_DEPTH);
  localparam logic [FAIL_W-1:0] FAIL_LIMIT = FAIL_W'(OVERSAMPLE_N);

  logic [SAMPLE_BITS-1:0] store [CHANNEL_SLOTS];
  logic [SUM_W-1:0]       sum;
  logic [FAIL_W-1:0]      fail_cnt;
  logic [CRED_W-1:0]      credits;

  logic [SLOT_W-1:0]      slot;
  logic [SAMPLE_BITS-1:0] smp;
  logic [SUM_W-1:0]       sum_next;
  logic [FAIL_W-1:0]      fail_next;
  logic                   is_sample;
  logic                   is_final;

  assign slot      = op.slot[SLOT_W-1:0];
  assign smp       = op.ok ? SAMPLE_BITS'(op.value) : store[slot];
  assign sum_next  = sum + SUM_W'(smp);
  assign fail_next = fail_cnt + FAIL_W'(!op.ok);
  assign is_sample = (op.kind == OP_SAMPLE);
  assign is_final  = is_sample && op.probe_b && op.last;
  assign op_pop    = op_valid && (!is_final || (credits != MAX_CRED));
  assign issue     = op_pop && is_final;
  assign sum_b     = sum_next;
  assign stalled   = (fail_next >= FAIL_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNEL_SLOTS; i++) begin
        store[i] <= '0;
      end
      sum      <= '0;
      sum_a    <= '0;
      fail_cnt <= '0;
    end else if (op_pop) begin
      if (!is_sample) begin
        sum      <= '0;
        sum_a    <= '0;
        fail_cnt <= '0;
      end else begin
        fail_cnt <= fail_next;
        if (op.ok) begin
          store[slot] <= SAMPLE_BITS'(op.value);
        end
        if (op.last) begin
          sum <= '0;
          if (!op.probe_b) begin
            sum_a <= sum_next;
          end
        end else begin
          sum <= sum_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      credits <= '0;
    end else if (issue && !res_pop) begin
      credits <= credits + 1'b1;
    end else if (res_pop && !issue) begin
      credits <= credits - 1'b1;
    end
  end

  `OVSF_ALWAYS(a_credit_bound, credits <= MAX_CRED, "result credits exceed queue depth")
  `OVSF_IMPLIES(a_pop_valid, op_pop, op_valid, "op taken from an empty queue")
  `OVSF_IMPLIES(a_issue_room, issue, credits < MAX_CRED, "result issued without queue room")
  `OVSF_NEXT(a_start_clears, op_pop && !is_sample, sum == '0 && fail_cnt == '0, "start left stale sums")

endmodule

@@ rtl/ovsf_finish.sv @@
module ovsf_finish #(
  parameter int OVERSAMPLE_N = 16,
  parameter int SUM_W        = 17
) (
  input  logic               clk,
  input  logic               rst,
  input  ovsf_pkg::cfg_t      cfg,
  input  logic               issue,
  input  logic [SUM_W-1:0]   sum_a,
  input  logic [SUM_W-1:0]   sum_b,
  input  logic               stalled,
  output logic               res_push,
  output ovsf_pkg::out_item_t res
);
  import ovsf_pkg::*;

  localparam int K      = SUM_W;
  localparam int RECIP_W = K + 1;
  localparam int PROD_W = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'((64'd1 << K) / OVERSAMPLE_N);
  localparam logic [SUM_W-1:0]   DIVISOR = SUM_W'(OVERSAMPLE_N);

  logic               s1_valid;
  logic [SUM_W-1:0]   s1_xa;
  logic [SUM_W-1:0]   s1_xb;
  logic [SUM_W-1:0]   s1_qa;
  logic [SUM_W-1:0]   s1_qb;
  logic               s1_stalled;
  logic               s2_valid;
  logic [SUM_W-1:0]   s2_qa;
  logic [SUM_W-1:0]   s2_qb;
  logic               s2_stalled;

  logic [PROD_W-1:0]  prod_a;
  logic [PROD_W-1:0]  prod_b;
  logic [SUM_W-1:0]   rem_a;
  logic [SUM_W-1:0]   rem_b;
  logic [FIELD_W-1:0] avg_a;
  logic [FIELD_W-1:0] avg_b;
  logic [FIELD_W:0]   pair;

  assign prod_a = PROD_W'(sum_a) * PROD_W'(RECIP);
  assign prod_b = PROD_W'(sum_b) * PROD_W'(RECIP);

  assign rem_a = s1_xa - SUM_W'(s1_qa * DIVISOR);
  assign rem_b = s1_xb - SUM_W'(s1_qb * DIVISOR);

  always_ff @(posedge clk) begin
    s1_xa      <= sum_a;
    s1_xb      <= sum_b;
    s1_qa      <= prod_a[K +: SUM_W];
    s1_qb      <= prod_b[K +: SUM_W];
    s1_stalled <= stalled;
    s2_qa      <= s1_qa + SUM_W'(rem_a >= DIVISOR);
    s2_qb      <= s1_qb + SUM_W'(rem_b >= DIVISOR);
    s2_stalled <= s1_stalled;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
    end
  end

  assign avg_a    = FIELD_W'(s2_qa);
  assign avg_b    = FIELD_W'(s2_qb);
  assign pair     = {1'b0, avg_a} + {1'b0, avg_b};
  assign res_push = s2_valid;

  always_comb begin
    res.probe_a_avg = avg_a;
    res.probe_b_avg = avg_b;
    res.stalled     = s2_stalled;
    case (cfg.probe_mode)
      MODE_A:  res.combined = avg_a;
      MODE_B:  res.combined = avg_b;
      default: res.combined = pair[FIELD_W:1];
    endcase
  end

endmodule

@@ sim/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ovsf_pkg::*;

  localparam int N = DEF_OVERSAMPLE_N;
  localparam int SLOTS = DEF_CHANNEL_SLOTS;
  localparam int SBITS = DEF_SAMPLE_BITS;
  localparam int RUN_CONVS = 2 * N + 2;
  localparam int SETTLE_CYCLES = 8;
  localparam int NUM_PHASES = 8;
  localparam logic [MODE_W-1:0] MODE_MEAN = 2'd2;
  localparam logic [MODE_W-1:0] MODE_MEAN_ALT = 2'd3;

  localparam int SHAPE_RANDOM = 0;
  localparam int SHAPE_MAX = 1;
  localparam int SHAPE_ZERO = 2;
  localparam int SHAPE_EDGES = 3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  in_item_t item = '0;
  logic full;
  logic pop = 1'b0;
  out_item_t result;
  logic empty;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  in_item_t conv_queue[$];
  out_item_t expected_results[$];
  int mismatches = 0;

  logic [FIELD_W-1:0] good_value [SLOTS];
  bit run_open;
  int run_count;
  int probe_sum;
  int held_a;
  int fail_count;
  cfg_t cfg_model;

  int burst_left = 1;
  int gap_left = 0;
  logic [7:0] stall_bits = 8'hFF;
  int watch_cycles = 0;

  oversample_with_last_good_fallback dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .item(item),
    .full(full),
    .pop(pop),
    .result(result),
    .empty(empty),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  function automatic int take_conv(logic [CHAN_W-1:0] chan, in_item_t it);
    int slot;
    int v;
    slot = int'(chan) % SLOTS;
    v = int'(it.sample) % (1 << SBITS);
    if (!it.sample_ok) begin
      fail_count++;
      return int'(good_value[slot]);
    end
    good_value[slot] = FIELD_W'(v);
    return v;
  endfunction

  function automatic bit acquire_step(in_item_t it, output out_item_t res);
    int k;
    int avg_b;
    int comb;
    res = '0;
    if (it.command == CMD_START) begin
      run_open = 1'b1;
      run_count = 0;
      probe_sum = 0;
      held_a = 0;
      fail_count = 0;
      return 1'b0;
    end
    if (!run_open) return 1'b0;
    k = run_count;
    run_count++;
    if (k == 0 || k == N + 1) return 1'b0;
    if (k <= N) begin
      probe_sum += take_conv(cfg_model.probe_a_channel, it);
      if (k == N) begin
        held_a = probe_sum / N;
        probe_sum = 0;
      end
      return 1'b0;
    end
    probe_sum += take_conv(cfg_model.probe_b_channel, it);
    if (k < 2 * N + 1) return 1'b0;
    avg_b = probe_sum / N;
    if (cfg_model.probe_mode == MODE_A) comb = held_a;
    else if (cfg_model.probe_mode == MODE_B) comb = avg_b;
    else comb = (held_a + avg_b) / 2;
    res.probe_a_avg = FIELD_W'(held_a);
    res.probe_b_avg = FIELD_W'(avg_b);
    res.combined = FIELD_W'(comb);
    res.stalled = (fail_count >= N);
    run_open = 1'b0;
    run_count = 0;
    probe_sum = 0;
    return 1'b1;
  endfunction

  always @(posedge clk) begin : drive
    out_item_t res;
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        if (acquire_step(item, res)) expected_results.push_back(res);
      end
      if (!push || !full) begin
        if (gap_left > 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (conv_queue.size() != 0) begin
          item <= conv_queue.pop_front();
          push <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
            gap_left = $urandom_range(1, 7);
          end
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch
    out_item_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no expectation waiting");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (result.probe_a_avg !== want.probe_a_avg) begin
            $error("probe_a_avg: expected %0d, got %0d", want.probe_a_avg, result.probe_a_avg);
            mismatches++;
          end
          if (result.probe_b_avg !== want.probe_b_avg) begin
            $error("probe_b_avg: expected %0d, got %0d", want.probe_b_avg, result.probe_b_avg);
            mismatches++;
          end
          if (result.combined !== want.combined) begin
            $error("combined: expected %0d, got %0d", want.combined, result.combined);
            mismatches++;
          end
          if (result.stalled !== want.stalled) begin
            $error("stalled: expected %0d, got %0d", want.stalled, result.stalled);
            mismatches++;
          end
        end
      end
      watch_cycles++;
      if (watch_cycles % 48 == 0) begin
        case ($urandom_range(0, 3))
          0: stall_bits = 8'hFF;
          1: stall_bits = 8'h01;
          2: stall_bits = 8'($urandom);
          default: stall_bits = 8'($urandom) | 8'($urandom);
        endcase
      end
      stall_bits = {stall_bits[0], stall_bits[7:1]};
      pop <= stall_bits[0];
    end
  end

  function automatic logic [FIELD_W-1:0] pick_sample(int shape);
    case (shape)
      SHAPE_MAX: return '1;
      SHAPE_ZERO: return '0;
      SHAPE_RANDOM: return FIELD_W'($urandom_range(0, 4095));
      default: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return '1;
          default: return FIELD_W'($urandom);
        endcase
      end
    endcase
  endfunction

  task automatic queue_item(logic cmd, logic [FIELD_W-1:0] smp, logic ok);
    in_item_t it;
    it.command = cmd;
    it.sample = smp;
    it.sample_ok = ok;
    conv_queue.push_back(it);
  endtask

  task automatic queue_convs(int count, int fail_pct, int shape);
    for (int i = 0; i < count; i++) begin
      queue_item(CMD_CONV, pick_sample(shape), $urandom_range(0, 99) >= fail_pct);
    end
  endtask

  task automatic queue_run(int fail_pct, int shape);
    queue_item(CMD_START, FIELD_W'($urandom), 1'($urandom));
    queue_convs(RUN_CONVS, fail_pct, shape);
  endtask

  function automatic int pick_fail_pct();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 5;
      2: return 30;
      3: return 60;
      4: return 100;
      default: return $urandom_range(0, 100);
    endcase
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (conv_queue.size() != 0 || push || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    case (idx)
      REG_PROBE_MODE: cfg_model.probe_mode = data[MODE_W-1:0];
      REG_A_CHANNEL: cfg_model.probe_a_channel = data[CHAN_W-1:0];
      REG_B_CHANNEL: cfg_model.probe_b_channel = data[CHAN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(cfg_t c);
    write_reg(REG_PROBE_MODE, CFG_DATA_W'(c.probe_mode));
    write_reg(REG_A_CHANNEL, CFG_DATA_W'(c.probe_a_channel));
    write_reg(REG_B_CHANNEL, CFG_DATA_W'(c.probe_b_channel));
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    cfg_t phase_cfg [NUM_PHASES];
    int carry;
    int partial;
    phase_cfg[0] = '{MODE_A, 4'd15, 4'd0};
    phase_cfg[1] = '{MODE_B, 4'd0, 4'd15};
    phase_cfg[2] = '{MODE_MEAN_ALT, 4'd7, 4'd7};
    phase_cfg[3] = '{MODE_MEAN, 4'd15, 4'd15};
    phase_cfg[4] = '{MODE_A, 4'd3, 4'd9};
    phase_cfg[5] = '{MODE_B, 4'd12, 4'd2};
    phase_cfg[6] = '{MODE_MEAN, 4'd5, 4'd10};
    phase_cfg[7] = '{MODE_MEAN_ALT, 4'd1, 4'd0};
    for (int i = 0; i < SLOTS; i++) good_value[i] = '0;
    run_open = 1'b0;
    run_count = 0;
    probe_sum = 0;
    held_a = 0;
    fail_count = 0;
    cfg_model = '{RST_PROBE_MODE, RST_A_CHANNEL, RST_B_CHANNEL};
    carry = 0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    queue_item(CMD_CONV, '1, 1'b1);
    queue_item(CMD_CONV, '0, 1'b0);
    queue_item(CMD_START, '1, 1'b1);
    queue_convs(5, 0, SHAPE_EDGES);
    queue_run(100, SHAPE_RANDOM);
    queue_run(0, SHAPE_MAX);
    queue_run(50, SHAPE_ZERO);
    queue_run(0, SHAPE_ZERO);
    wait_idle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      apply_config(phase_cfg[p]);
      if (carry > 0) queue_convs(carry, pick_fail_pct(), SHAPE_EDGES);
      carry = 0;
      for (int r = 0; r < 5; r++) begin
        case ($urandom_range(0, 9))
          0: begin
            repeat ($urandom_range(1, 3)) begin
              queue_item(CMD_CONV, FIELD_W'($urandom), 1'($urandom));
            end
          end
          1: begin
            queue_item(CMD_START, FIELD_W'($urandom), 1'($urandom));
            queue_convs($urandom_range(0, RUN_CONVS - 1), pick_fail_pct(), SHAPE_RANDOM);
          end
          default: ;
        endcase
        queue_run(pick_fail_pct(), ($urandom_range(0, 3) == 0) ? SHAPE_EDGES : SHAPE_RANDOM);
      end
      if (p % 2 == 0 && p != NUM_PHASES - 1) begin
        partial = $urandom_range(1, RUN_CONVS - 1);
        queue_item(CMD_START, FIELD_W'($urandom), 1'($urandom));
        queue_convs(partial, pick_fail_pct(), SHAPE_RANDOM);
        carry = RUN_CONVS - partial;
      end
      wait_idle();
    end

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("oversample_with_last_good_fallback test passed");
    end else begin
      $display("oversample_with_last_good_fallback test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(2_000_000);
    $display("oversample_with_last_good_fallback test failed");
    $finish;
  end

endmodule
